/* rtl/core/fre_pkg.sv */
`default_nettype none
package fre_pkg;
  localparam int DEFAULT_FRAME = 1024;
  localparam logic [0:0] CFG_FRAME = 1'b0;
  localparam logic [0:0] CFG_HOP   = 1'b1;
endpackage
`default_nettype wire

/* rtl/core/framed_rms_envelope.sv */
`default_nettype none
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/in_stall  | in_sample, in_stream_start
// out     | output    | out_valid/out_stall| out_rms_level, out_frame_number
// cfg     | input     | cfg_we             | cfg_index, cfg_data
// A request that closes no window passes S_READ (ring read) and S_UPD (sum
// update and ring write). A closing window adds a restoring divide (S_DIV),
// a root (S_ROOT) and a load of the output register (S_OUT); the shared
// iteration counter it_r steps both the divide and the root. Reset is
// synchronous and clears control state; the ring needs no clearing since
// entries are read only after being written. The result sits in an output
// register, so a stalled out side holds only the next closing window, which
// waits with in_stall high.
module framed_rms_envelope #(
  parameter int MAX_WINDOW  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [SAMPLE_BITS-1:0] in_sample,
  input  wire                          in_stream_start,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [15:0]                  out_rms_level,
  output logic [23:0]                  out_frame_number,
  input  wire                          cfg_we,
  input  wire  [15:0]                  cfg_index,
  input  wire  [15:0]                  cfg_data
);
  localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FW    = $clog2(MAX_WINDOW + 1);
  localparam int SQ_W  = 2 * SAMPLE_BITS - 1;
  // sum width rounded up to even so the root consumes whole digit pairs
  localparam int SUM_W = SQ_W + FW + ((SQ_W + FW) % 2);
  localparam int RMS_W = (SUM_W + 1) / 2;
  localparam int CW    = $clog2(SUM_W + 1);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_UPD, S_DIV, S_ROOT, S_OUT} state_t;
  state_t state_r;

  logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_r, smp_r;
  logic [12:0] frame_r;
  logic [15:0] hop_r;
  logic [SUM_W-1:0] sum_r;
  logic [AW-1:0] ptr_r;
  logic [FW-1:0] fill_r;
  logic [15:0] hcnt_r;
  logic [23:0] win_r;
  logic [SUM_W-1:0] quo_r, rem_r;
  logic [CW-1:0] it_r;
  logic [SUM_W+1:0] rrem_r;
  logic [RMS_W-1:0] root_r;

  // effective frame and hop
  logic [FW-1:0] f_eff;
  logic [15:0] h_eff;
  always_comb begin
    if (frame_r == 13'd0) f_eff = FW'(fre_pkg::DEFAULT_FRAME);
    else if (32'(frame_r) > MAX_WINDOW) f_eff = FW'(MAX_WINDOW);
    else f_eff = FW'(frame_r);
    if (f_eff > FW'(MAX_WINDOW)) f_eff = FW'(MAX_WINDOW);
    h_eff = (hop_r == 16'd0) ? 16'(f_eff) : hop_r;
  end

  function automatic logic [SQ_W-1:0] sq(input logic [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS-1:0] m;
    m = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
    return SQ_W'(m) * SQ_W'(m);
  endfunction

  // oldest entry: ptr - f modulo MAX_WINDOW
  logic [AW:0] old_w;
  always_comb begin
    if ({1'b0, ptr_r} >= (AW+1)'(f_eff)) old_w = {1'b0, ptr_r} - (AW+1)'(f_eff);
    else old_w = {1'b0, ptr_r} + (AW+1)'(MAX_WINDOW) - (AW+1)'(f_eff);
  end

  logic [SUM_W-1:0] q_old, sum_sub;
  always_comb begin
    q_old = SUM_W'(sq(rd_r));
    sum_sub = (fill_r >= f_eff) ? ((sum_r >= q_old) ? sum_r - q_old : '0) : sum_r;
  end

  logic [SUM_W:0] dtry;
  logic [SUM_W+1:0] rtry;
  always_comb begin
    dtry = {rem_r, quo_r[SUM_W-1]} - (SUM_W+1)'(f_eff);
    rtry = {rrem_r[SUM_W-1:0], quo_r[SUM_W-1:SUM_W-2]} - (SUM_W+2)'({root_r, 2'b01});
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) ring[ptr_r] <= smp_r;
    rd_r <= ring[old_w[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; frame_r <= 13'(fre_pkg::DEFAULT_FRAME);
      hop_r <= 16'(fre_pkg::DEFAULT_FRAME); sum_r <= '0; ptr_r <= '0;
      fill_r <= '0; hcnt_r <= '0; win_r <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_we && cfg_index[15:1] == 15'd0) begin
        if (cfg_index[0] == fre_pkg::CFG_FRAME) frame_r <= cfg_data[12:0];
        else hop_r <= cfg_data;
        sum_r <= '0; ptr_r <= '0; fill_r <= '0; hcnt_r <= '0; win_r <= '0;
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          smp_r <= in_sample;
          if (in_stream_start) begin
            sum_r <= '0; ptr_r <= '0; fill_r <= '0; hcnt_r <= '0; win_r <= '0;
          end
          state_r <= S_READ;
        end
        S_READ: state_r <= S_UPD; // rd_r valid next cycle
        S_UPD: begin
          logic emit;
          logic [SUM_W-1:0] ns;
          ns = sum_sub + SUM_W'(sq(smp_r));
          sum_r <= ns;
          ptr_r <= (32'(ptr_r) + 1 >= MAX_WINDOW) ? '0 : ptr_r + 1'b1;
          emit = 1'b0;
          if (fill_r < f_eff) begin
            fill_r <= fill_r + 1'b1;
            if (fill_r + 1'b1 == f_eff) begin emit = 1'b1; hcnt_r <= h_eff; end
          end else begin
            fill_r <= f_eff;
            if (hcnt_r > 16'd1) hcnt_r <= hcnt_r - 1'b1;
            else begin emit = 1'b1; hcnt_r <= h_eff; end
          end
          quo_r <= ns; rem_r <= '0; it_r <= '0;
          state_r <= emit ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (!dtry[SUM_W]) begin
            rem_r <= dtry[SUM_W-1:0]; quo_r <= {quo_r[SUM_W-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[SUM_W-2:0], quo_r[SUM_W-1]}; quo_r <= {quo_r[SUM_W-2:0], 1'b0};
          end
          it_r <= it_r + 1'b1;
          if (32'(it_r) == SUM_W - 1) begin
            state_r <= S_ROOT; it_r <= '0; rrem_r <= '0; root_r <= '0;
          end
        end
        S_ROOT: begin
          // digit-pair shift of the quotient; SUM_W is even, RMS_W pairs cover it
          if (!rtry[SUM_W+1]) begin
            rrem_r <= rtry; root_r <= {root_r[RMS_W-2:0], 1'b1};
          end else begin
            rrem_r <= {rrem_r[SUM_W-1:0], quo_r[SUM_W-1:SUM_W-2]};
            root_r <= {root_r[RMS_W-2:0], 1'b0};
          end
          quo_r <= {quo_r[SUM_W-3:0], 2'b00};
          it_r <= it_r + 1'b1;
          if (32'(it_r) == RMS_W - 1) state_r <= S_OUT;
        end
        S_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          out_rms_level <= 16'(root_r);
          out_frame_number <= win_r;
          win_r <= win_r + 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rms_level)) else $error("out lost");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> in_stall) else $error("accept while busy");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(MAX_WINDOW)) else $error("fill overflow");
endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  localparam int RING_DEPTH = 4096;
  // settle time after the last result, enough for one window close
  localparam int SETTLE = 200;
  localparam longint CYCLE_LIMIT = 2000000;
  // register indexes that the block does not decode
  localparam logic [15:0] CFG_SPARE_IDX = 16'd2;
  localparam logic [15:0] CFG_HIGH_IDX  = 16'h8001;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_sample;
  logic in_stream_start;
  logic out_valid;
  logic out_stall;
  logic [15:0] out_rms_level;
  logic [23:0] out_frame_number;
  logic cfg_we;
  logic [15:0] cfg_index;
  logic [15:0] cfg_data;

  framed_rms_envelope dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample(in_sample), .in_stream_start(in_stream_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_rms_level(out_rms_level), .out_frame_number(out_frame_number),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [15:0] rms_level;
    logic [23:0] frame_number;
  } envelope_t;

  envelope_t pending_levels[$];
  int errors = 0;
  int idle_pct = 0;   // sender gap chance, percent
  int stall_pct = 0;  // receiver stall chance, percent
  longint cycles = 0;

  // Shadow of the block: registers and stream state
  logic [12:0] frame_reg;
  logic [15:0] hop_reg;
  logic [15:0] ring_shadow [RING_DEPTH];
  longint unsigned energy;
  int unsigned wr_ptr, filled, hop_left;
  logic [23:0] window_idx;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** framed_rms_envelope: FAILED **");
      $finish;
    end
  end

  // random backpressure on the result side
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  function automatic logic [15:0] floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[15:0];
  endfunction

  function automatic longint unsigned sq(logic [15:0] s);
    longint v;
    v = longint'($signed(s));
    return longint'(v * v);
  endfunction

  function automatic int unsigned window_len();
    int unsigned f;
    f = frame_reg;
    if (f == 0) f = fre_pkg::DEFAULT_FRAME;
    if (f > RING_DEPTH) f = RING_DEPTH;
    return f;
  endfunction

  function automatic void clear_stream();
    energy = 0;
    wr_ptr = 0;
    filled = 0;
    hop_left = 0;
    window_idx = '0;
  endfunction

  // Advance the shadow by one accepted sample; queue a level on window close
  function automatic void predict_sample(logic [15:0] s, logic start);
    int unsigned f, h, old;
    bit closes;
    f = window_len();
    h = (hop_reg == 0) ? f : hop_reg;
    closes = 0;
    if (start) clear_stream();
    if (filled >= f) begin
      old = (wr_ptr >= f) ? wr_ptr - f : wr_ptr + RING_DEPTH - f;
      energy = energy - sq(ring_shadow[old]);
    end
    ring_shadow[wr_ptr] = s;
    energy = energy + sq(s);
    wr_ptr = (wr_ptr + 1 >= RING_DEPTH) ? 0 : wr_ptr + 1;
    if (filled < f) begin
      filled++;
      if (filled == f) begin
        closes = 1;
        hop_left = h;
      end
    end else if (hop_left > 1) begin
      hop_left--;
    end else begin
      closes = 1;
      hop_left = h;
    end
    if (closes) begin
      pending_levels.push_back({floor_root(energy / f), window_idx});
      window_idx = window_idx + 1;
    end
  endfunction

  // One request on the input side; returns at the accepting edge
  task automatic send_sample(logic [15:0] s, logic start);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_stream_start <= start;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    predict_sample(s, start);
  endtask

  // Lower valid and wait for all levels plus any result-free request in flight
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_levels.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [15:0] idx, logic [15:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == 16'(fre_pkg::CFG_FRAME)) begin
      frame_reg = data[12:0];
      clear_stream();
    end else if (idx == 16'(fre_pkg::CFG_HOP)) begin
      hop_reg = data;
      clear_stream();
    end
  endtask

  // Result checker: sample at negedge, accepted at the next rising edge
  always @(negedge clk) begin
    envelope_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        $error("unexpected result: rms_level %0d frame_number %0d",
               out_rms_level, out_frame_number);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        if (out_rms_level !== want.rms_level) begin
          $error("rms_level expected %0d actual %0d", want.rms_level, out_rms_level);
          errors++;
        end
        if (out_frame_number !== want.frame_number) begin
          $error("frame_number expected %0d actual %0d",
                 want.frame_number, out_frame_number);
          errors++;
        end
      end
    end
  end

  // Small frame: extremes, stream start mid-window, undecoded indexes
  task automatic test_directed();
    write_reg(16'(fre_pkg::CFG_FRAME), 16'd4);
    write_reg(16'(fre_pkg::CFG_HOP), 16'd0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8000, 1'b1);   // restart mid-stream
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);   // full-scale window, level 32768
    // hold off the sender until the pipe is empty
    drain();
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h1234, 1'b0);
    // undecoded indexes must not touch the stream
    write_reg(CFG_SPARE_IDX, 16'd1);
    write_reg(CFG_HIGH_IDX, 16'd1);
    for (int i = 0; i < 8; i++) send_sample(16'($urandom), 1'b0);
  endtask

  // Hop below, equal to and above the frame; hop extremes
  task automatic test_hop_shapes();
    write_reg(16'(fre_pkg::CFG_FRAME), 16'd3);
    write_reg(16'(fre_pkg::CFG_HOP), 16'd1);
    for (int i = 0; i < 12; i++) send_sample(16'($urandom), 1'b0);
    write_reg(16'(fre_pkg::CFG_HOP), 16'd3);
    for (int i = 0; i < 12; i++) send_sample(16'($urandom), 1'b0);
    write_reg(16'(fre_pkg::CFG_HOP), 16'd7);
    for (int i = 0; i < 20; i++) send_sample(16'($urandom), 1'b0);
    write_reg(16'(fre_pkg::CFG_FRAME), 16'd1);
    write_reg(16'(fre_pkg::CFG_HOP), 16'hFFFF);
    for (int i = 0; i < 20; i++) send_sample(16'($urandom), 1'b0);
  endtask

  // Saturating frame register (too few samples to close) and the default window
  task automatic test_window_extremes();
    write_reg(16'(fre_pkg::CFG_HOP), 16'd0);
    write_reg(16'(fre_pkg::CFG_FRAME), 16'hFFFF);
    for (int i = 0; i < 40; i++)
      send_sample(($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF, 1'b0);
    write_reg(16'(fre_pkg::CFG_FRAME), 16'd0);
    for (int i = 0; i < fre_pkg::DEFAULT_FRAME + 40; i++)
      send_sample(16'($urandom), 1'b0);
  endtask

  // Random frames and hops under each idling profile
  task automatic test_random_streams(int gap, int stall);
    int unsigned n;
    logic [15:0] s;
    idle_pct = gap;
    stall_pct = stall;
    n = 0;
    while (n < 175) begin
      write_reg(16'(fre_pkg::CFG_FRAME), ($urandom_range(9) == 0) ? 16'($urandom)
                                                                    : 16'($urandom_range(24, 1)));
      write_reg(16'(fre_pkg::CFG_HOP), 16'($urandom_range(30)));
      for (int i = 0; i < 60; i++) begin
        case ($urandom_range(3))
          0: s = 16'($urandom);
          1: s = 16'($signed($urandom_range(200)) - 100);
          2: s = ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
          default: s = 16'($urandom_range(16'hFFFF));
        endcase
        // big windows only see random frames briefly: no result there, still fine
        send_sample(s, $urandom_range(39) == 0);
        n++;
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_stream_start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    frame_reg = 13'(fre_pkg::DEFAULT_FRAME);
    hop_reg = 16'(fre_pkg::DEFAULT_FRAME);
    clear_stream();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_hop_shapes();
    test_window_extremes();
    test_random_streams(0, 0);
    test_random_streams(66, 0);
    test_random_streams(0, 66);
    test_random_streams(15, 15);

    drain();
    if (errors == 0) begin
      $display("** framed_rms_envelope: PASSED **");
    end else begin
      $display("** framed_rms_envelope: FAILED **");
    end
    $finish;
  end
endmodule
